[rtl/tccw_pkg.sv]
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared constants, types and helpers for the text console cursor writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 4;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = 11;
    localparam int CELL_W = 16;
    localparam int CHAR_W = 8;

    // column plus tab gets a spare carry bit, row plus one likewise
    localparam int COLX_W = COL_W + 1;
    localparam int ROWX_W = ROW_W + 1;
    localparam int IDX_W  = 13;

    localparam logic [ROW_W-1:0] FIRST_TEXT_ROW = ROW_W'(1);
    localparam logic [COL_W-1:0] FIRST_COLUMN   = '0;

    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CODE_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'h20;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_TEXT_COLOR = 1'b0;
    localparam logic [7:0] TEXT_COLOR_RESET = 8'h07;

    typedef struct packed {
        logic                  write_enable;
        logic [ADDR_W-1:0]     write_address;
        logic [CELL_W-1:0]     write_cell;
        logic [COL_W-1:0]      cursor_column;
        logic [ROW_W-1:0]      cursor_row;
        logic [ADDR_W-1:0]     cursor_index;
    } result_t;

    function automatic logic [ADDR_W-1:0] cell_index(
        input logic [COL_W-1:0] col,
        input logic [ROW_W-1:0] row
    );
        logic [IDX_W-1:0] idx;
        idx = IDX_W'(row) * IDX_W'(COLUMNS) + IDX_W'(col);
        return idx[ADDR_W-1:0];
    endfunction

endpackage

[rtl/text_console_cursor_writer_core.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_writer_core
// Cursor tracking console writer for a text-mode screen buffer.
// ----------------------------------------------------------------------------
// One character code enters per input beat (in_valid / in_stall). Each beat
// gives exactly one output beat (out_valid / out_stall) carrying the screen
// cell write, if any, and the cursor position after the character.
// A beat is taken at a clock edge where valid is high and stall is low.
// From input beat to output beat there is one input register,
// then the decode and cursor update feed the result register. Throughput is
// one character per cycle while the receiver does not stall; the cursor
// column and row registers close a loop through the decode logic.
// When the receiver stalls, the result register holds its beat and the input
// register can still take one more character; in_stall rises only once both
// are full.
// Reset (rst_n low, asynchronous) empties both registers, puts the cursor at
// column 0 of row 1 and sets text_color to 7. text_color is written over the
// APB port with paddr[2] low and should only change while the block is idle.
// ----------------------------------------------------------------------------
module text_console_cursor_writer_core
    import tccw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CHAR_W-1:0]  char_code,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               write_enable,
    output logic [ADDR_W-1:0]  write_address,
    output logic [CELL_W-1:0]  write_cell,
    output logic [COL_W-1:0]   cursor_column,
    output logic [ROW_W-1:0]   cursor_row,
    output logic [ADDR_W-1:0]  cursor_index
);

    logic [7:0]        text_color;
    logic              in_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              out_valid_reg;
    result_t           result_reg;
    result_t           result_next;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic              advance;

    tccw_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .text_color (text_color)
    );

    tccw_cursor u_cursor (
        .char_code  (char_reg),
        .col        (col_reg),
        .row        (row_reg),
        .text_color (text_color),
        .result     (result_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            char_reg <= char_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            col_reg       <= FIRST_COLUMN;
            row_reg       <= FIRST_TEXT_ROW;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            col_reg       <= result_next.cursor_column;
            row_reg       <= result_next.cursor_row;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_enable  = result_reg.write_enable;
    assign write_address = result_reg.write_address;
    assign write_cell    = result_reg.write_cell;
    assign cursor_column = result_reg.cursor_column;
    assign cursor_row    = result_reg.cursor_row;
    assign cursor_index  = result_reg.cursor_index;

    // cursor never enters the status bar or runs off the screen
    a_cursor_in_text_area: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg >= FIRST_TEXT_ROW) && (ROW_W'(ROWS) > row_reg || ROWS > 31)
        && (COL_W'(COLUMNS) > col_reg || COLUMNS > 127))
        else $error("cursor left the text area");

    // the beat on the output always reflects the cursor state it produced
    a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.cursor_column == col_reg)
                          && (result_reg.cursor_row == row_reg))
        else $error("output cursor differs from cursor state");

    // a result with no write carries a clean address and cell
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_reg.write_enable) |->
            (result_reg.write_address == '0) && (result_reg.write_cell == '0))
        else $error("idle write carries data");

    // cursor state only moves when a beat enters the result register
    a_state_moves_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(col_reg) && $stable(row_reg))
        else $error("cursor moved without a character");

endmodule

[rtl/tccw_cfg.sv]
// ----------------------------------------------------------------------------
// tccw_cfg
// APB register file holding the text color attribute.
// ----------------------------------------------------------------------------
module tccw_cfg
    import tccw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [7:0]         text_color
);

    logic [7:0] text_color_reg;
    logic       wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_TEXT_COLOR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= TEXT_COLOR_RESET;
        end
        else if (wr_hit)
        begin
            text_color_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_TEXT_COLOR)
        begin
            prdata = PDATA_W'(text_color_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    assign text_color = text_color_reg;

endmodule

[rtl/tccw_cursor.sv]
// ----------------------------------------------------------------------------
// tccw_cursor
// Decodes one character against the current cursor and forms the cell write
// and the next cursor position.
// ----------------------------------------------------------------------------
module tccw_cursor
    import tccw_pkg::*;
(
    input  logic [CHAR_W-1:0] char_code,
    input  logic [COL_W-1:0]  col,
    input  logic [ROW_W-1:0]  row,
    input  logic [7:0]        text_color,
    output result_t           result
);

    logic [COLX_W-1:0] col_w;
    logic [ROWX_W-1:0] row_w;
    logic [COL_W-1:0]  col_n;
    logic [ROW_W-1:0]  row_n;

    always_comb
    begin
        col_w = COLX_W'(col);
        row_w = ROWX_W'(row);
        result.write_enable  = 1'b0;
        result.write_address = '0;
        result.write_cell    = '0;

        unique case (char_code)
            CODE_NEWLINE:
            begin
                col_w = '0;
                row_w = row_w + ROWX_W'(1);
            end
            CODE_RETURN:
            begin
                col_w = '0;
            end
            CODE_BACKSPACE:
            begin
                if (col != '0)
                begin
                    col_w = COLX_W'(col - COL_W'(1));
                    result.write_enable  = 1'b1;
                    result.write_address = cell_index(col - COL_W'(1), row);
                    result.write_cell    = {text_color, CODE_SPACE};
                end
            end
            CODE_TAB:
            begin
                col_w = col_w + COLX_W'(TAB_WIDTH);
            end
            default:
            begin
                result.write_enable  = 1'b1;
                result.write_address = cell_index(col, row);
                result.write_cell    = {text_color, char_code};
                col_w = col_w + COLX_W'(1);
            end
        endcase

        // wrap at the right edge, overflow is dropped
        if (col_w >= COLX_W'(COLUMNS))
        begin
            col_w = '0;
            row_w = row_w + ROWX_W'(1);
        end
        // row 0 is the status bar, so wrap back to the first text row
        if (row_w >= ROWX_W'(ROWS))
        begin
            row_w = ROWX_W'(FIRST_TEXT_ROW);
        end

        col_n = col_w[COL_W-1:0];
        row_n = row_w[ROW_W-1:0];
        result.cursor_column = col_n;
        result.cursor_row    = row_n;
        result.cursor_index  = cell_index(col_n, row_n);
    end

endmodule
